/* hw/rtl/i2cmbe_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types, register indexes, command codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbe_pkg;

	localparam int UnitW    = 16;
	localparam int PollW    = 8;
	localparam int ByteW    = 8;
	localparam int FuncW    = 3;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 16;

	localparam logic [UnitW-1:0] UNIT_TICKS_RST = 16'd64;
	localparam logic [PollW-1:0] POLL_LIMIT_RST = 8'd250;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_UNIT_TICKS     = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_ACK_POLL_LIMIT = 1'b1;

	// Command codes.
	localparam logic [FuncW-1:0] FUNC_NONE     = 3'd0;
	localparam logic [FuncW-1:0] FUNC_START    = 3'd1;
	localparam logic [FuncW-1:0] FUNC_STOP     = 3'd2;
	localparam logic [FuncW-1:0] FUNC_WRITE    = 3'd3;
	localparam logic [FuncW-1:0] FUNC_READ     = 3'd4;
	localparam logic [FuncW-1:0] FUNC_SEND_ACK = 3'd5;
	localparam logic [FuncW-1:0] FUNC_GET_ACK  = 3'd6;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_ST_H1    = 5'd1,
		PH_ST_H2    = 5'd2,
		PH_ST_L1    = 5'd3,
		PH_ST_L2    = 5'd4,
		PH_SP_L1    = 5'd5,
		PH_SP_L2    = 5'd6,
		PH_SP_H1    = 5'd7,
		PH_SP_H2    = 5'd8,
		PH_GA_W1    = 5'd9,
		PH_GA_W2    = 5'd10,
		PH_GA_POLL  = 5'd11,
		PH_SA_LOW   = 5'd12,
		PH_SA_HIGH  = 5'd13,
		PH_WR_SETUP = 5'd14,
		PH_WR_HIGH  = 5'd15,
		PH_WR_LOW   = 5'd16,
		PH_RD_LOW   = 5'd17,
		PH_RD_HIGH  = 5'd18
	} phase_t;

	typedef struct packed {
		logic [UnitW-1:0] unit_ticks;
		logic [PollW-1:0] ack_poll_limit;
	} cfg_t;

	typedef struct packed {
		logic [FuncW-1:0] func;
		logic [ByteW-1:0] tx_byte;
		logic             ack_level;
		logic             sda_in;
	} in_item_t;

	typedef struct packed {
		logic             scl;
		logic             sda_out;
		logic             sda_oe;
		logic             busy_res;
		logic             done_res;
		logic [ByteW-1:0] rx_byte;
		logic             ack_status;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/i2cmbe_if.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine channels
// Valid/ready channels for the tick items and the pin/status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cmbe_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] tx_byte;
	logic       ack_level;
	logic       sda_in;

	modport source (output valid, output func, output tx_byte, output ack_level,
		output sda_in, input ready);
	modport sink (input valid, input func, input tx_byte, input ack_level,
		input sda_in, output ready);
endinterface

interface i2cmbe_out_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_out;
	logic       sda_oe;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_status;

	modport source (output valid, output scl, output sda_out, output sda_oe,
		output busy_res, output done_res, output rx_byte, output ack_status,
		input ready);
	modport sink (input valid, input scl, input sda_out, input sda_oe,
		input busy_res, input done_res, input rx_byte, input ack_status,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/i2cmbe_core.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine sequencer core
// Holds the bus sequencer state and works out one tick's update and result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbe_core (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       accept,
	input  wire i2cmbe_pkg::cfg_t     cfg,
	input  wire i2cmbe_pkg::in_item_t item,
	output i2cmbe_pkg::result_t       res
);

	i2cmbe_pkg::phase_t phase_q, phase_d;
	logic [15:0] delay_q, delay_d;
	logic [3:0]  bit_count_q, bit_count_d;
	logic [7:0]  shift_q, shift_d;
	logic [7:0]  poll_count_q, poll_count_d;
	logic [7:0]  received_q, received_d;
	logic        ack_flag_q, ack_flag_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        oe_q, oe_d;
	logic        done;

	logic [15:0] unit_len;
	logic        poll_end;
	logic        bit_last;

	assign unit_len = (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks;
	assign poll_end = !item.sda_in || (poll_count_q >= cfg.ack_poll_limit);
	// The eighth bit has just gone by when the count reaches seven.
	assign bit_last = (bit_count_q >= 4'd7);

	// Next phase, delay and completion.
	always_comb begin
		phase_d = phase_q;
		delay_d = delay_q;
		done    = 1'b0;
		if (accept) begin
			priority if (phase_q == i2cmbe_pkg::PH_IDLE) begin
				unique case (item.func)
					i2cmbe_pkg::FUNC_START: begin
						phase_d = i2cmbe_pkg::PH_ST_H1;
						delay_d = unit_len;
					end
					i2cmbe_pkg::FUNC_STOP: begin
						phase_d = i2cmbe_pkg::PH_SP_L1;
						delay_d = unit_len;
					end
					i2cmbe_pkg::FUNC_WRITE: begin
						phase_d = i2cmbe_pkg::PH_WR_SETUP;
						delay_d = 16'd1;
					end
					i2cmbe_pkg::FUNC_READ: begin
						phase_d = i2cmbe_pkg::PH_RD_LOW;
						delay_d = unit_len;
					end
					i2cmbe_pkg::FUNC_SEND_ACK: begin
						phase_d = i2cmbe_pkg::PH_SA_LOW;
						delay_d = unit_len;
					end
					i2cmbe_pkg::FUNC_GET_ACK: begin
						phase_d = i2cmbe_pkg::PH_GA_W1;
						delay_d = unit_len;
					end
					default: begin
					end
				endcase
			end else if (phase_q == i2cmbe_pkg::PH_GA_POLL) begin
				if (poll_end) begin
					phase_d = i2cmbe_pkg::PH_IDLE;
					delay_d = 16'd0;
					done    = 1'b1;
				end
			end else if (delay_q > 16'd1) begin
				delay_d = delay_q - 16'd1;
			end else begin
				delay_d = unit_len;
				unique case (phase_q)
					i2cmbe_pkg::PH_ST_H1:    phase_d = i2cmbe_pkg::PH_ST_H2;
					i2cmbe_pkg::PH_ST_H2:    phase_d = i2cmbe_pkg::PH_ST_L1;
					i2cmbe_pkg::PH_ST_L1:    phase_d = i2cmbe_pkg::PH_ST_L2;
					i2cmbe_pkg::PH_SP_L1:    phase_d = i2cmbe_pkg::PH_SP_L2;
					i2cmbe_pkg::PH_SP_L2:    phase_d = i2cmbe_pkg::PH_SP_H1;
					i2cmbe_pkg::PH_SP_H1:    phase_d = i2cmbe_pkg::PH_SP_H2;
					i2cmbe_pkg::PH_GA_W1:    phase_d = i2cmbe_pkg::PH_GA_W2;
					i2cmbe_pkg::PH_SA_LOW:   phase_d = i2cmbe_pkg::PH_SA_HIGH;
					i2cmbe_pkg::PH_WR_SETUP: phase_d = i2cmbe_pkg::PH_WR_HIGH;
					i2cmbe_pkg::PH_WR_HIGH:  phase_d = i2cmbe_pkg::PH_WR_LOW;
					i2cmbe_pkg::PH_RD_LOW:   phase_d = i2cmbe_pkg::PH_RD_HIGH;
					i2cmbe_pkg::PH_GA_W2: begin
						phase_d = i2cmbe_pkg::PH_GA_POLL;
						delay_d = 16'd0;
					end
					i2cmbe_pkg::PH_ST_L2, i2cmbe_pkg::PH_SP_H2,
					i2cmbe_pkg::PH_SA_HIGH: begin
						phase_d = i2cmbe_pkg::PH_IDLE;
						delay_d = 16'd0;
						done    = 1'b1;
					end
					i2cmbe_pkg::PH_WR_LOW: begin
						if (bit_last) begin
							phase_d = i2cmbe_pkg::PH_IDLE;
							delay_d = 16'd0;
							done    = 1'b1;
						end else begin
							phase_d = i2cmbe_pkg::PH_WR_SETUP;
							delay_d = 16'd1;
						end
					end
					i2cmbe_pkg::PH_RD_HIGH: begin
						if (bit_last) begin
							phase_d = i2cmbe_pkg::PH_IDLE;
							delay_d = 16'd0;
							done    = 1'b1;
						end else begin
							phase_d = i2cmbe_pkg::PH_RD_LOW;
						end
					end
					default: begin
						phase_d = i2cmbe_pkg::PH_IDLE;
						delay_d = 16'd0;
					end
				endcase
			end
		end
	end

	// Pin levels and data registers.
	always_comb begin
		bit_count_d  = bit_count_q;
		shift_d      = shift_q;
		poll_count_d = poll_count_q;
		received_d   = received_q;
		ack_flag_d   = ack_flag_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		oe_d         = oe_q;
		if (accept) begin
			priority if (phase_q == i2cmbe_pkg::PH_IDLE) begin
				unique case (item.func)
					i2cmbe_pkg::FUNC_START: begin
						oe_d  = 1'b1;
						sda_d = 1'b1;
						scl_d = 1'b1;
					end
					i2cmbe_pkg::FUNC_STOP: begin
						oe_d  = 1'b1;
						sda_d = 1'b0;
						scl_d = 1'b0;
					end
					i2cmbe_pkg::FUNC_WRITE: begin
						oe_d        = 1'b1;
						scl_d       = 1'b0;
						shift_d     = item.tx_byte;
						bit_count_d = 4'd0;
						sda_d       = item.tx_byte[7];
					end
					i2cmbe_pkg::FUNC_READ: begin
						oe_d        = 1'b0;
						scl_d       = 1'b0;
						shift_d     = 8'd0;
						bit_count_d = 4'd0;
					end
					i2cmbe_pkg::FUNC_SEND_ACK: begin
						oe_d  = 1'b1;
						scl_d = 1'b0;
						sda_d = item.ack_level;
					end
					i2cmbe_pkg::FUNC_GET_ACK: begin
						oe_d  = 1'b0;
						sda_d = 1'b1;
					end
					default: begin
					end
				endcase
			end else if (phase_q == i2cmbe_pkg::PH_GA_POLL) begin
				if (!item.sda_in) begin
					scl_d      = 1'b0;
					ack_flag_d = 1'b0;
				end else if (poll_end) begin
					// Timeout leaves SCL high.
					ack_flag_d = 1'b1;
				end else begin
					poll_count_d = poll_count_q + 8'd1;
				end
			end else if (delay_q > 16'd1) begin
			end else begin
				unique case (phase_q)
					i2cmbe_pkg::PH_ST_H2:    sda_d = 1'b0;
					i2cmbe_pkg::PH_ST_L2:    scl_d = 1'b0;
					i2cmbe_pkg::PH_SP_L2:    scl_d = 1'b1;
					i2cmbe_pkg::PH_SP_H2:    sda_d = 1'b1;
					i2cmbe_pkg::PH_GA_W1:    scl_d = 1'b0;
					i2cmbe_pkg::PH_SA_LOW:   scl_d = 1'b1;
					i2cmbe_pkg::PH_SA_HIGH:  scl_d = 1'b0;
					i2cmbe_pkg::PH_WR_SETUP: scl_d = 1'b1;
					i2cmbe_pkg::PH_WR_HIGH:  scl_d = 1'b0;
					i2cmbe_pkg::PH_RD_LOW:   scl_d = 1'b1;
					i2cmbe_pkg::PH_GA_W2: begin
						scl_d        = 1'b1;
						poll_count_d = 8'd0;
					end
					i2cmbe_pkg::PH_WR_LOW: begin
						shift_d     = {shift_q[6:0], 1'b0};
						bit_count_d = bit_count_q + 4'd1;
						if (!bit_last) begin
							sda_d = shift_q[6];
						end
					end
					i2cmbe_pkg::PH_RD_HIGH: begin
						shift_d     = {shift_q[6:0], item.sda_in};
						bit_count_d = bit_count_q + 4'd1;
						scl_d       = 1'b0;
						if (bit_last) begin
							received_d = {shift_q[6:0], item.sda_in};
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cmbe_pkg::PH_IDLE;
			delay_q      <= 16'd0;
			bit_count_q  <= 4'd0;
			shift_q      <= 8'd0;
			poll_count_q <= 8'd0;
			received_q   <= 8'd0;
			ack_flag_q   <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			oe_q         <= 1'b1;
		end else begin
			phase_q      <= phase_d;
			delay_q      <= delay_d;
			bit_count_q  <= bit_count_d;
			shift_q      <= shift_d;
			poll_count_q <= poll_count_d;
			received_q   <= received_d;
			ack_flag_q   <= ack_flag_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
			oe_q         <= oe_d;
		end
	end

	always_comb begin
		res.scl        = scl_d;
		res.sda_out    = sda_d;
		res.sda_oe     = oe_d;
		res.busy_res   = (phase_d != i2cmbe_pkg::PH_IDLE);
		res.done_res   = done;
		res.rx_byte    = received_d;
		res.ack_status = ack_flag_d;
	end

`ifndef SYNTHESIS
	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q <= 4'd8)
		else $error("bit counter ran past eight");

	a_delay_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != i2cmbe_pkg::PH_IDLE && phase_q != i2cmbe_pkg::PH_GA_POLL)
		|-> (delay_q != 16'd0))
		else $error("timed phase with an empty delay count");

	a_hold_without_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q) && $stable(delay_q))
		else $error("sequencer moved without a transfer");

	a_none_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == i2cmbe_pkg::PH_IDLE && item.func == i2cmbe_pkg::FUNC_NONE)
		|=> (phase_q == i2cmbe_pkg::PH_IDLE))
		else $error("empty command left idle");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && done) |=> (phase_q == i2cmbe_pkg::PH_IDLE))
		else $error("completion without return to idle");
`endif

endmodule

`default_nettype wire

/* hw/rtl/i2c_master_byte_engine.sv */
// The result of a tick item is registered and presented in the cycle after its transfer.
// Throughput: one tick item per cycle; the sequencer state updates in one pass.
// A new item is taken when the output register is empty or its result leaves.
// Reset: asynchronous, active low; idle, SCL and SDA high with SDA driven,
// unit_ticks 64 and ack_poll_limit 250.
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master pin sequencer with a plain configuration write port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [i2cmbe_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire  [i2cmbe_pkg::CfgDataW-1:0]    cfg_data,
	i2cmbe_in_if.sink                          req,
	i2cmbe_out_if.source                       rsp
);

	i2cmbe_pkg::cfg_t     cfg_q;
	i2cmbe_pkg::in_item_t item;
	i2cmbe_pkg::result_t  res_d;
	i2cmbe_pkg::result_t  rsp_q;
	logic                 rsp_valid_q;
	logic                 accept;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	always_comb begin
		item.func      = req.func;
		item.tx_byte   = req.tx_byte;
		item.ack_level = req.ack_level;
		item.sda_in    = req.sda_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_ticks     <= i2cmbe_pkg::UNIT_TICKS_RST;
			cfg_q.ack_poll_limit <= i2cmbe_pkg::POLL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cmbe_pkg::CFG_UNIT_TICKS:     cfg_q.unit_ticks     <= cfg_data;
				i2cmbe_pkg::CFG_ACK_POLL_LIMIT: cfg_q.ack_poll_limit <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	i2cmbe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cfg    (cfg_q),
		.item   (item),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= res_d;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.scl        = rsp_q.scl;
	assign rsp.sda_out    = rsp_q.sda_out;
	assign rsp.sda_oe     = rsp_q.sda_oe;
	assign rsp.busy_res   = rsp_q.busy_res;
	assign rsp.done_res   = rsp_q.done_res;
	assign rsp.rx_byte    = rsp_q.rx_byte;
	assign rsp.ack_status = rsp_q.ack_status;

endmodule

`default_nettype wire
